[src/bqte_pkg.sv]
`default_nettype none

package bqte_pkg;

  localparam int CHANNELS       = 8;
  localparam int CH_AW          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EXP_TABLE_SIZE = 256;
  localparam int EXP_LOG2       = $clog2(EXP_TABLE_SIZE);
  localparam int EXP_IW         = EXP_LOG2 + 1;
  localparam int EXP_W          = 31;

  localparam int SMP_W  = 24;
  localparam int GAIN_W = 16;
  localparam int FRAC_W = 16;
  localparam int ACC_W  = 64;
  localparam int MPL_W  = 24;
  localparam int DIG_W  = 4;
  localparam int NDIG_W = 3;
  localparam int HIST_W = 4 * SMP_W;

  localparam logic [NDIG_W-1:0] NDIG_COEF = NDIG_W'(MPL_W / DIG_W);
  localparam logic [NDIG_W-1:0] NDIG_GAIN = NDIG_W'(GAIN_W / DIG_W);

  // register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_B0     = 3'd1;
  localparam logic [2:0] REG_B1     = 3'd2;
  localparam logic [2:0] REG_B2     = 3'd3;
  localparam logic [2:0] REG_A1     = 3'd4;
  localparam logic [2:0] REG_A2     = 3'd5;
  localparam logic [2:0] REG_DRIVE  = 3'd6;
  localparam logic [2:0] REG_LEVEL  = 3'd7;

  localparam logic [1:0] MODE_BYPASS = 2'd0;
  localparam logic [1:0] MODE_SHAPE  = 2'd1;
  localparam logic [1:0] MODE_FILT   = 2'd2;

  typedef logic [EXP_W-1:0] exp_rom_t [0:EXP_TABLE_SIZE];

  typedef struct packed {
    logic              start;
    logic              clr;
    logic              neg;
    logic              sgn;
    logic [NDIG_W-1:0] ndig;
  } mac_cmd_t;

  // exp(-16k/N) in Q.30, geometric series from a Taylor ratio
  function automatic exp_rom_t build_rom();
    exp_rom_t    rom;
    logic [63:0] h;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] prod;
    rom  = '{default: '0};
    h    = (64'd16 << 32) / EXP_TABLE_SIZE;
    term = 64'd1 << 32;
    r    = term;
    for (int i = 1; i <= 12; i++) begin
      term = ((term * h) >> 32) / 64'(i);
      if (i % 2 == 1) r = r - term;
      else            r = r + term;
    end
    rom[0] = EXP_W'(64'd1 << 30);
    for (int i = 0; i < EXP_TABLE_SIZE; i++) begin
      prod       = (64'(rom[i]) * r + (64'd1 << 31)) >> 32;
      rom[i + 1] = EXP_W'(prod);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_rom();

  function automatic logic [SMP_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
    logic [SMP_W-1:0] r;
    if (v > 64'sd8388607)       r = 24'h7FFFFF;
    else if (v < -64'sd8388608) r = 24'h800000;
    else                        r = v[SMP_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

[src/bqte_ram.sv]
`default_nettype none

module bqte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

[src/bqte_mac.sv]
`default_nettype none

// digit-serial multiply-accumulate: DIG_W multiplier bits per cycle, LSB first
module bqte_mac (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bqte_pkg::mac_cmd_t          cmd,
  input  wire logic [bqte_pkg::ACC_W-1:0]  mcand,
  input  wire logic [bqte_pkg::MPL_W-1:0]  mplier,
  output logic                             done,
  output logic      [bqte_pkg::ACC_W-1:0]  acc
);
  import bqte_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [NDIG_W-1:0] cnt_r;
  logic              neg_r;
  logic              sgn_r;
  logic [ACC_W-1:0]  mc_r;
  logic [MPL_W-1:0]  mp_r;
  logic [ACC_W-1:0]  acc_r;

  logic              last;
  logic [DIG_W-1:0]  dig;
  logic [ACC_W-1:0]  pp;
  logic [ACC_W-1:0]  acc_nxt;

  always_comb begin
    last = (cnt_r == NDIG_W'(1));
    dig  = mp_r[DIG_W-1:0];
    pp   = (dig[0] ? mc_r : '0) + (dig[1] ? (mc_r << 1) : '0) + (dig[2] ? (mc_r << 2) : '0);
    // top digit of a signed multiplier carries negative weight
    if (dig[3]) pp = (last && sgn_r) ? (pp - (mc_r << 3)) : (pp + (mc_r << 3));
    acc_nxt = neg_r ? (acc_r - pp) : (acc_r + pp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= cmd.ndig;
      end else if (busy_r) begin
        cnt_r <= cnt_r - NDIG_W'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mc_r  <= mcand;
      mp_r  <= mplier;
      neg_r <= cmd.neg;
      sgn_r <= cmd.sgn;
      if (cmd.clr) acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      mc_r  <= mc_r << DIG_W;
      mp_r  <= mp_r >> DIG_W;
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

`default_nettype wire

[src/biquad_tone_exp_waveshaper.sv]
`default_nettype none

// Channel   Handshake             Payload
// in_       in_valid / in_stall   in_channel[2:0], in_sample_in[23:0] signed Q1.23
// out_      out_valid / out_stall out_sample_out[23:0] signed Q1.23
// cfg_      cfg_valid / cfg_ready cfg_index[2:0], cfg_data[23:0]
//
// One beat at a time through a 4-bit digit-serial MAC; the MAC sets the rate.
// Mode 0 runs no product; shaper only runs up to three 4-digit products (two
// when the argument runs past the table); filter plus shaper first runs five
// 6-digit products, then up to three 4-digit products.
// Reset clears the config to defaults and marks all channel histories empty.
// A result parks in the output register under out_stall; the next input beat
// is taken as soon as the result has moved into that register.
module biquad_tone_exp_waveshaper (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_channel,
  input  wire logic signed [23:0] in_sample_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [23:0]      out_sample_out,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);
  import bqte_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HIST = 4'd1;
  localparam logic [3:0] S_FILT = 4'd2;
  localparam logic [3:0] S_FOUT = 4'd3;
  localparam logic [3:0] S_GAIN = 4'd4;
  localparam logic [3:0] S_ROM  = 4'd5;
  localparam logic [3:0] S_INTP = 4'd6;
  localparam logic [3:0] S_LVL  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  // config
  logic [1:0]        mode_r;
  logic [SMP_W-1:0]  b0_r, b1_r, b2_r, a1_r, a2_r;
  logic [GAIN_W-1:0] drive_r, level_r;

  // sequencer
  logic [3:0]        state_r;
  logic              go_r;
  logic [2:0]        term_r;
  logic [2:0]        chan_r;
  logic              ok_r;
  logic [CHANNELS-1:0] vld_r;

  // datapath
  logic [SMP_W-1:0]  x_r, x1_r, x2_r, y1_r, y2_r;
  logic [SMP_W-1:0]  v_r, res_r;
  logic [EXP_W-1:0]  hi_r, diff_r, e_r;
  logic [FRAC_W-1:0] f_r;
  logic              out_valid_r;
  logic [SMP_W-1:0]  out_r;

  logic              accept;
  logic              load_out;
  mac_cmd_t          cmd;
  logic [ACC_W-1:0]  mcand;
  logic [MPL_W-1:0]  mplier;
  logic              mac_done;
  logic [ACC_W-1:0]  acc;

  logic [HIST_W-1:0] rd_row;
  logic              ram_we;
  logic [HIST_W-1:0] wr_row;
  logic [CH_AW-1:0]  ch_addr;

  logic [SMP_W-1:0]  mag;
  logic [SMP_W-1:0]  y_new;
  logic [ACC_W-1:0]  rnd;
  logic [ACC_W-1:0]  idx_full;
  logic [EXP_LOG2-1:0] idx;
  logic [ACC_W-1:0]  outm;
  logic [SMP_W-1:0]  shaped;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign ch_addr   = CH_AW'(chan_r);

  // MAC operand selection
  always_comb begin
    mag      = v_r[SMP_W-1] ? (SMP_W'(0) - v_r) : v_r;
    cmd      = '0;
    cmd.start = go_r;
    mcand    = '0;
    mplier   = '0;
    unique case (state_r)
      S_FILT: begin
        cmd.clr  = (term_r == 3'd0);
        cmd.neg  = (term_r >= 3'd3);
        cmd.sgn  = 1'b1;
        cmd.ndig = NDIG_COEF;
        unique case (term_r)
          3'd0:    begin mcand = ACC_W'($signed(x_r));  mplier = b0_r; end
          3'd1:    begin mcand = ACC_W'($signed(x1_r)); mplier = b1_r; end
          3'd2:    begin mcand = ACC_W'($signed(x2_r)); mplier = b2_r; end
          3'd3:    begin mcand = ACC_W'($signed(y1_r)); mplier = a1_r; end
          3'd4:    begin mcand = ACC_W'($signed(y2_r)); mplier = a2_r; end
          default: begin mcand = '0;                    mplier = '0;   end
        endcase
      end
      S_GAIN: begin
        cmd.clr  = 1'b1;
        cmd.ndig = NDIG_GAIN;
        mcand    = ACC_W'(mag);
        mplier   = MPL_W'(drive_r);
      end
      S_INTP: begin
        cmd.clr  = 1'b1;
        cmd.ndig = NDIG_GAIN;
        mcand    = ACC_W'(diff_r);
        mplier   = MPL_W'(f_r);
      end
      S_LVL: begin
        cmd.clr  = 1'b1;
        cmd.ndig = NDIG_GAIN;
        mcand    = ACC_W'(EXP_ROM[0] - e_r);
        mplier   = MPL_W'(level_r);
      end
      default: ;
    endcase
  end

  // result arithmetic on the finished accumulator
  always_comb begin
    rnd      = '0;
    y_new    = '0;
    outm     = '0;
    shaped   = '0;
    idx_full = acc >> (35 - EXP_LOG2);
    idx      = idx_full[EXP_LOG2-1:0];
    unique case (state_r)
      S_FOUT: begin
        rnd   = acc + (ACC_W'(1) << 19);
        y_new = sat24($signed(rnd) >>> 20);
      end
      S_INTP: rnd = acc + (ACC_W'(1) << 15);
      S_LVL: begin
        rnd    = acc + (ACC_W'(1) << 21);
        outm   = rnd >> 22;
        shaped = sat24(v_r[SMP_W-1] ? $signed(ACC_W'(0) - outm) : $signed(outm));
      end
      default: ;
    endcase
  end

  // history row: newest input, older input, newest output, older output
  assign ram_we = (state_r == S_FOUT) && ok_r;
  assign wr_row = {x_r, x1_r, y_new, y1_r};

  bqte_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .mcand  (mcand),
    .mplier (mplier),
    .done   (mac_done),
    .acc    (acc)
  );

  bqte_ram #(
    .WIDTH (HIST_W),
    .DEPTH (CHANNELS)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ch_addr),
    .wdata (wr_row),
    .raddr (CH_AW'(in_channel)),
    .rdata (rd_row)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      term_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_BYPASS;
      b0_r        <= 24'd1048576;
      b1_r        <= '0;
      b2_r        <= '0;
      a1_r        <= '0;
      a2_r        <= '0;
      drive_r     <= 16'd256;
      level_r     <= 16'd32768;
    end else begin
      go_r <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MODE:  mode_r  <= cfg_data[1:0];
          REG_B0:    b0_r    <= cfg_data;
          REG_B1:    b1_r    <= cfg_data;
          REG_B2:    b2_r    <= cfg_data;
          REG_A1:    a1_r    <= cfg_data;
          REG_A2:    a2_r    <= cfg_data;
          REG_DRIVE: drive_r <= cfg_data[GAIN_W-1:0];
          REG_LEVEL: level_r <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
        out_r       <= res_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            x_r    <= in_sample_in;
            v_r    <= in_sample_in;
            res_r  <= in_sample_in;
            chan_r <= in_channel;
            ok_r   <= ({29'd0, in_channel} < 32'(CHANNELS));
            if (mode_r == MODE_BYPASS) begin
              state_r <= S_DONE;
            end else if (mode_r == MODE_FILT) begin
              state_r <= S_HIST;
            end else begin
              state_r <= S_GAIN;
              go_r    <= 1'b1;
            end
          end
        end
        S_HIST: begin
          // empty or out-of-range channel filters against zero history
          if (ok_r && vld_r[ch_addr]) begin
            {x1_r, x2_r, y1_r, y2_r} <= rd_row;
          end else begin
            {x1_r, x2_r, y1_r, y2_r} <= '0;
          end
          term_r  <= '0;
          state_r <= S_FILT;
          go_r    <= 1'b1;
        end
        S_FILT: begin
          if (mac_done) begin
            if (term_r == 3'd4) begin
              state_r <= S_FOUT;
            end else begin
              term_r <= term_r + 3'd1;
              go_r   <= 1'b1;
            end
          end
        end
        S_FOUT: begin
          v_r <= y_new;
          if (ok_r) vld_r[ch_addr] <= 1'b1;
          state_r <= S_GAIN;
          go_r    <= 1'b1;
        end
        S_GAIN: begin
          if (mac_done) state_r <= S_ROM;
        end
        S_ROM: begin
          // argument past the table end clamps to the last entry
          if (idx_full >= ACC_W'(EXP_TABLE_SIZE)) begin
            e_r     <= EXP_ROM[EXP_TABLE_SIZE];
            state_r <= S_LVL;
          end else begin
            hi_r    <= EXP_ROM[{1'b0, idx}];
            diff_r  <= EXP_ROM[{1'b0, idx}] - EXP_ROM[{1'b0, idx} + EXP_IW'(1)];
            f_r     <= acc[34-EXP_LOG2 -: FRAC_W];
            state_r <= S_INTP;
          end
          go_r <= 1'b1;
        end
        S_INTP: begin
          if (mac_done) begin
            e_r     <= hi_r - EXP_W'(rnd >> 16);
            state_r <= S_LVL;
            go_r    <= 1'b1;
          end
        end
        S_LVL: begin
          if (mac_done) begin
            res_r   <= shaped;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;

endmodule

`default_nettype wire

[src/bqte_chk.sv]
`default_nettype none

module bqte_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [23:0] out_sample_out,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out))
    else $error("stalled result changed");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while busy");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a beat in flight");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind biquad_tone_exp_waveshaper bqte_chk u_bqte_chk (.*);

`default_nettype wire
